/* src/sctc_pkg.sv */
`timescale 1ns / 1ps
// Package for the scan code to console character converter.
// Holds character constants, the queue entry type and the key map functions.
// No dependencies.
package sctc_pkg;

  localparam logic [7:0] KeyPrefix = 8'hE0;
  localparam logic [7:0] EscChar   = 8'd27;
  localparam logic [7:0] CsiChar   = 8'h5B;
  localparam logic [7:0] CrChar    = 8'h0D;
  localparam logic [7:0] LfChar    = 8'h0A;
  localparam logic [7:0] BsChar    = 8'h08;
  localparam logic [7:0] NoChar    = 8'h00;
  localparam logic [7:0] ScUp      = 8'h48;
  localparam logic [7:0] ScDown    = 8'h50;
  localparam logic [7:0] ScLeft    = 8'h4B;
  localparam logic [7:0] ScRight   = 8'h4D;

  localparam logic SrcKeyboard = 1'b0;
  localparam logic SrcSerial   = 1'b1;

  // Queue between classifier and character emitter.
  localparam int QueueDepth = 4;
  localparam int PtrWidth   = $clog2(QueueDepth);
  localparam int CountWidth = $clog2(QueueDepth + 1);

  // One classified beat: a single character, or an arrow key that expands
  // into ESC '[' letter.
  typedef struct packed {
    logic       arrow;
    logic [7:0] ch;
  } sctc_entry_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic empty;
    logic full;
  } sctc_qstat_t;

  // Set 1 make code to character; NoChar when unmapped.
  function automatic logic [7:0] make_char(input logic [6:0] code);
    logic [7:0] c;
    c = NoChar;
    unique case (code)
      7'h02: c = "1";
      7'h03: c = "2";
      7'h04: c = "3";
      7'h05: c = "4";
      7'h06: c = "5";
      7'h07: c = "6";
      7'h08: c = "7";
      7'h09: c = "8";
      7'h0A: c = "9";
      7'h0B: c = "0";
      7'h0E: c = BsChar;
      7'h10: c = "q";
      7'h11: c = "w";
      7'h12: c = "e";
      7'h13: c = "r";
      7'h14: c = "t";
      7'h15: c = "y";
      7'h16: c = "u";
      7'h17: c = "i";
      7'h18: c = "o";
      7'h19: c = "p";
      7'h1C: c = LfChar;
      7'h1E: c = "a";
      7'h1F: c = "s";
      7'h20: c = "d";
      7'h21: c = "f";
      7'h22: c = "g";
      7'h23: c = "h";
      7'h24: c = "j";
      7'h25: c = "k";
      7'h26: c = "l";
      7'h2C: c = "z";
      7'h2D: c = "x";
      7'h2E: c = "c";
      7'h2F: c = "v";
      7'h30: c = "b";
      7'h31: c = "n";
      7'h32: c = "m";
      7'h39: c = " ";
      default: c = NoChar;
    endcase
    return c;
  endfunction

  // Arrow scan code to final letter of the escape sequence; NoChar otherwise.
  function automatic logic [7:0] arrow_letter(input logic [7:0] code);
    logic [7:0] c;
    c = NoChar;
    unique case (code)
      ScUp:    c = "A";
      ScDown:  c = "B";
      ScRight: c = "C";
      ScLeft:  c = "D";
      default: c = NoChar;
    endcase
    return c;
  endfunction

endpackage

/* src/sctc_front.sv */
`timescale 1ns / 1ps
// Front part: classifies each accepted byte and holds the extended prefix flag.
// Depends on sctc_pkg.
module sctc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               opcode,
  input  logic [7:0]         data_byte,
  output logic               enq,
  output sctc_pkg::sctc_entry_t enq_entry
);

  logic       extended_pending;
  logic       extended_pending_next;
  logic [7:0] letter;
  logic [7:0] mapped;

  always_comb begin
    letter                = sctc_pkg::arrow_letter(data_byte);
    mapped                = sctc_pkg::make_char(data_byte[6:0]);
    extended_pending_next = extended_pending;
    enq                   = 1'b0;
    enq_entry.arrow       = 1'b0;
    enq_entry.ch          = data_byte;
    if (opcode == sctc_pkg::SrcSerial) begin
      enq = accept;
      if (data_byte == sctc_pkg::CrChar) begin
        enq_entry.ch = sctc_pkg::LfChar;
      end
    end else if (data_byte == sctc_pkg::KeyPrefix) begin
      extended_pending_next = 1'b1;
    end else begin
      // Any other keyboard byte consumes the prefix.
      extended_pending_next = 1'b0;
      if (!data_byte[7]) begin
        if (letter != sctc_pkg::NoChar) begin
          enq             = accept & extended_pending;
          enq_entry.arrow = 1'b1;
          enq_entry.ch    = letter;
        end else begin
          enq          = accept & (mapped != sctc_pkg::NoChar);
          enq_entry.ch = mapped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
    end else if (accept) begin
      extended_pending <= extended_pending_next;
    end
  end

endmodule

/* src/sctc_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified beats between the front and back parts.
// Depends on sctc_pkg.
module sctc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  enq,
  input  sctc_pkg::sctc_entry_t enq_entry,
  input  logic                  deq,
  output sctc_pkg::sctc_entry_t head,
  output sctc_pkg::sctc_qstat_t stat
);

  sctc_pkg::sctc_entry_t                 slots [sctc_pkg::QueueDepth];
  logic [sctc_pkg::PtrWidth-1:0]         wr_ptr;
  logic [sctc_pkg::PtrWidth-1:0]         rd_ptr;
  logic [sctc_pkg::CountWidth-1:0]       count;
  logic                                  do_enq;
  logic                                  do_deq;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == sctc_pkg::CountWidth'(sctc_pkg::QueueDepth));
  assign head       = slots[rd_ptr];
  assign do_enq     = enq & ~stat.full;
  assign do_deq     = deq & ~stat.empty;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slots[wr_ptr] <= enq_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_enq && !do_deq) begin
        count <= count + 1'b1;
      end else if (do_deq && !do_enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/sctc_back.sv */
`timescale 1ns / 1ps
// Back part: expands queued beats into console characters in an output register.
// Depends on sctc_pkg.
module sctc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sctc_pkg::sctc_entry_t head,
  input  sctc_pkg::sctc_qstat_t qstat,
  output logic                  deq,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            out_char,
  output logic                  last_of_run
);

  logic       out_valid;
  logic       advance;
  logic       pend;        // arrow sequence in progress
  logic       phase;       // 0: '[' next, 1: letter next
  logic [7:0] letter;

  assign empty   = ~out_valid;
  assign advance = ~out_valid | pop;
  assign deq     = advance & ~pend & ~qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (advance) begin
      if (pend) begin
        out_valid <= 1'b1;
        if (phase) begin
          pend <= 1'b0;
        end
      end else if (!qstat.empty) begin
        out_valid <= 1'b1;
        pend      <= head.arrow;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and sequence position.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend) begin
        if (phase) begin
          out_char    <= letter;
          last_of_run <= 1'b1;
        end else begin
          out_char    <= sctc_pkg::CsiChar;
          last_of_run <= 1'b0;
          phase       <= 1'b1;
        end
      end else if (!qstat.empty) begin
        letter <= head.ch;
        phase  <= 1'b0;
        if (head.arrow) begin
          out_char    <= sctc_pkg::EscChar;
          last_of_run <= 1'b0;
        end else begin
          out_char    <= head.ch;
          last_of_run <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/scancode_to_console_char.sv */
`timescale 1ns / 1ps
// Top level of the scan code to console character converter.
// Depends on sctc_pkg, sctc_front, sctc_queue and sctc_back.
//
// Usage:
//   Input channel: drive opcode (0 keyboard scan code, 1 serial byte) and
//   data_byte, raise push; the beat is taken at an edge with push high and
//   full low. full rises only when the internal four-entry queue is full.
//   Result channel: while empty is low, out_char and last_of_run show the
//   oldest character; it is taken at an edge with pop high.
//   A byte yields zero, one or three characters; last_of_run marks the
//   final one of each run. Bytes that yield nothing only update the
//   extended prefix flag.
//   Path: a byte is written into the queue at the edge that takes it and
//   moves from there into the output register when the path is free.
//   Throughput: one byte per cycle in while full is low, one character
//   per cycle out while pop is high; an arrow key occupies the output
//   register for three characters, so the emitter bounds the sustained rate.
//   Reset (rst, synchronous) clears the prefix flag, the queue and the
//   output register. When the receiver holds pop low, the result stays
//   put, the queue fills, and full then holds off further input.
module scancode_to_console_char (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_of_run
);

  logic                  accept;
  logic                  enq;
  logic                  deq;
  sctc_pkg::sctc_entry_t enq_entry;
  sctc_pkg::sctc_entry_t head;
  sctc_pkg::sctc_qstat_t qstat;

  // Take a beat whenever the queue has room; classification is combinational.
  assign full   = qstat.full;
  assign accept = push & ~qstat.full;

  sctc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (opcode),
    .data_byte (data_byte),
    .enq       (enq),
    .enq_entry (enq_entry)
  );

  // Decouple classification from expansion so each side stalls on its own.
  sctc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq       (enq),
    .enq_entry (enq_entry),
    .deq       (deq),
    .head      (head),
    .stat      (qstat)
  );

  // Expand arrow keys into ESC '[' letter; advance one character each time the output register is free or popped.
  sctc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .deq         (deq),
    .pop         (pop),
    .empty       (empty),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule
